// File: rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue core.
package deq_pkg;

   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_REAR  = 3'd1,
      CMD_DEL_FRONT = 3'd2,
      CMD_DEL_REAR  = 3'd3,
      CMD_SHOW      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam int unsigned WORD_W = 32;

   typedef struct packed {
      logic       ins_front;
      logic       ins_rear;
      logic       del_front;
      logic       del_rear;
      logic       show_start;
      logic       show_step;
      logic       emit_status;
      status_type status_code;
   } ctrl_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic show_last;
      logic pending;
   } dp_stat_type;

endpackage

// File: rtl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/deq_datapath.sv
// Datapath of the queue: pointers, element count, ring store and result registers.
module deq_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  deq_pkg::ctrl_cmd_type cmd,
   input  logic signed [31:0]    req_value,
   output deq_pkg::dp_stat_type  stat,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_status,
   output logic signed [31:0]    rsp_element,
   output logic                  rsp_last
);

   import deq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;
   localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
   localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   logic [AW-1:0]     front_ff, front_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic              tag_valid_ff, tag_last_ff;
   logic              rsp_strobe_ff;
   status_type        rsp_status_ff;
   logic [WORD_W-1:0] rsp_element_ff;
   logic              rsp_last_ff;

   logic [AW-1:0]     front_dec, front_inc, rd_ptr_inc, wr_addr;
   logic [SW-1:0]     rear_sum, rear_pos;
   logic [WORD_W-1:0] rd_data;
   logic              wr_en;

   assign front_dec  = (front_ff == '0) ? LAST_POS : front_ff - AW'(1);
   assign front_inc  = (front_ff == LAST_POS) ? '0 : front_ff + AW'(1);
   assign rd_ptr_inc = (rd_ptr_ff == LAST_POS) ? '0 : rd_ptr_ff + AW'(1);
   assign rear_sum   = SW'(front_ff) + SW'(count_ff);
   assign rear_pos   = (rear_sum >= DEPTH_S) ? rear_sum - DEPTH_S : rear_sum;

   assign wr_en   = cmd.ins_front || cmd.ins_rear;
   assign wr_addr = cmd.ins_front ? front_dec : rear_pos[AW-1:0];

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      rem_in    = rem_ff;
      if (cmd.ins_front) begin
         front_in = front_dec;
         count_in = count_ff + CW'(1);
      end else if (cmd.ins_rear) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.del_front) begin
         front_in = front_inc;
         count_in = count_ff - CW'(1);
      end else if (cmd.del_rear) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.show_start) begin
         rd_ptr_in = front_ff;
         rem_in    = count_ff;
      end else if (cmd.show_step) begin
         rd_ptr_in = rd_ptr_inc;
         rem_in    = rem_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         count_ff      <= '0;
         tag_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         front_ff      <= front_in;
         count_ff      <= count_in;
         tag_valid_ff  <= cmd.show_step;
         rsp_strobe_ff <= cmd.emit_status || tag_valid_ff;
      end
      rd_ptr_ff   <= rd_ptr_in;
      rem_ff      <= rem_in;
      tag_last_ff <= (rem_ff == CW'(1));
      if (cmd.emit_status) begin
         rsp_status_ff  <= cmd.status_code;
         rsp_element_ff <= '0;
         rsp_last_ff    <= 1'b1;
      end else begin
         rsp_status_ff  <= ST_OK;
         rsp_element_ff <= rd_data;
         rsp_last_ff    <= tag_last_ff;
      end
   end

   deq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (cmd.show_step),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == DEPTH_C);
   assign stat.show_last = (rem_ff == CW'(1));
   assign stat.pending   = tag_valid_ff;

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = $signed(rsp_element_ff);
   assign rsp_last    = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("element count exceeds the store depth");
   a_no_collision: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_status |-> !tag_valid_ff)
      else $error("status word collides with a display word");
   a_step_has_work: assert property (@(posedge clock) disable iff (reset)
      cmd.show_step |-> rem_ff != '0)
      else $error("display step issued with nothing left to read");
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !stat.full && !tag_valid_ff)
      else $error("insert into a full store or during a display");
`endif

endmodule

// File: rtl/deq_ctrl.sv
// Controller of the queue: decodes commands and sequences the display stream.
module deq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0]            req_command,
   input  deq_pkg::dp_stat_type  stat,
   output deq_pkg::ctrl_cmd_type cmd,
   output logic                  busy
);

   import deq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SHOW
   } state_type;

   state_type state_ff, state_in;
   cmd_type   op;
   logic      accept;

   assign op     = cmd_type'(req_command);
   assign busy   = (state_ff == S_SHOW) || stat.pending;
   assign accept = start && !busy;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      if (state_ff == S_SHOW) begin
         cmd.show_step = 1'b1;
         if (stat.show_last) begin
            state_in = S_IDLE;
         end
      end else if (accept) begin
         unique case (op)
            CMD_INS_FRONT: begin
               if (stat.full) begin
                  cmd.emit_status = 1'b1;
                  cmd.status_code = ST_FULL;
               end else begin
                  cmd.ins_front = 1'b1;
               end
            end
            CMD_INS_REAR: begin
               if (stat.full) begin
                  cmd.emit_status = 1'b1;
                  cmd.status_code = ST_FULL;
               end else begin
                  cmd.ins_rear = 1'b1;
               end
            end
            CMD_DEL_FRONT: begin
               if (stat.empty) begin
                  cmd.emit_status = 1'b1;
                  cmd.status_code = ST_EMPTY;
               end else begin
                  cmd.del_front = 1'b1;
               end
            end
            CMD_DEL_REAR: begin
               if (stat.empty) begin
                  cmd.emit_status = 1'b1;
                  cmd.status_code = ST_EMPTY;
               end else begin
                  cmd.del_rear = 1'b1;
               end
            end
            CMD_SHOW: begin
               if (stat.empty) begin
                  cmd.emit_status = 1'b1;
                  cmd.status_code = ST_EMPTY;
               end else begin
                  cmd.show_start = 1'b1;
                  state_in       = S_SHOW;
               end
            end
            default: begin
               cmd = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_show_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.show_start |=> state_ff == S_SHOW)
      else $error("display accepted but the stream did not begin");
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.ins_front, cmd.ins_rear, cmd.del_front, cmd.del_rear,
                cmd.show_start, cmd.show_step, cmd.emit_status}))
      else $error("more than one datapath action in a cycle");
   a_busy_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHOW && stat.show_last) |=> busy)
      else $error("busy dropped before the last display word left");
`endif

endmodule

// File: rtl/double_ended_queue_core.sv
// Top level of the bounded double-ended queue core.
// A word is accepted when start is high and busy is low. Inserts and deletes never raise
// busy, so one may be issued every cycle; a refused command gives a single status word
// in the cycle after acceptance. A display of N elements keeps busy high while it reads
// the ring store and returns one word per cycle, front to rear, each passing the store's
// single registered read port, which sets the pace, and then the result register.
// Results cannot be held off by the receiver. No clearing pass follows reset.
module double_ended_queue_core #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_element,
   output logic               rsp_last
);

   import deq_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   deq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_value   (req_value),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_element (rsp_element),
      .rsp_last    (rsp_last)
   );

endmodule
